### rtl/afr_pkg.sv
// Shared types and constants for the addressed frame receiver.
`timescale 1ns / 1ps

package afr_pkg;

    // Framing bytes
    localparam logic [7:0] START_BYTE  = 8'h06;
    localparam logic [7:0] MARKER_BYTE = 8'h85;

    // Result kinds
    localparam logic [1:0] KIND_GOOD = 2'd0;
    localparam logic [1:0] KIND_SIZE = 2'd1;
    localparam logic [1:0] KIND_CSUM = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_OWN_ADDR   = 1'b0;
    localparam logic REG_FRAME_SIZE = 1'b1;

    // Depth of the result queue and width of its fill count
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CW    = $clog2(OUT_DEPTH) + 1;

    // Depth of the command queue between front and back
    localparam int CMD_DEPTH = 2;

    // Command from the front end to the back end
    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] count;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       send_ack;
    } t_result;

endpackage

### rtl/afr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module afr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/afr_queue.sv
// Small register-based FIFO with fill count.
`timescale 1ns / 1ps

module afr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH) + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wp  = do_push ? r_wp + AW'(1) : r_wp;
        n_rp  = do_pop ? r_rp + AW'(1) : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store pushed entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Count must track pointer distance
    a_count_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) == AW'(r_cnt))
        else $error("queue count disagrees with pointers");

endmodule

### rtl/afr_front.sv
// Front end: frame parser, payload store writer and command issue.
`timescale 1ns / 1ps

module afr_front #(
    parameter int MAX_PAYLOAD = 64,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_rx_byte,
    output logic          o_full,
    input  logic [7:0]    i_own_address,
    input  logic [6:0]    i_frame_size,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output logic          o_cmd_push,
    output afr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_full,
    input  logic          i_drain_done
);
    import afr_pkg::*;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_MARK  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    localparam logic [6:0] MAX_P = 7'(MAX_PAYLOAD);

    logic [2:0] r_phase, n_phase;
    logic [6:0] r_count, n_count;
    logic [7:0] r_check, n_check;
    logic       r_drain_pend, n_drain_pend;
    logic       accept;
    logic       size_bad;
    logic [6:0] count_inc;

    // Stall on status-issuing phases when the command queue is full,
    // and on payload bytes while the previous good frame still drains
    assign o_full = ((r_phase == PH_MARK || r_phase == PH_CHECK) && i_cmd_full) ||
                    (r_phase == PH_DATA && r_drain_pend);
    assign accept = i_push && !o_full;

    assign size_bad  = (i_frame_size == '0) || (i_frame_size > MAX_P) ||
                       (r_check != {1'b0, i_frame_size});
    assign count_inc = r_count + 7'd1;

    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = i_rx_byte;

    // Parse one byte per accepted request
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_check      = r_check;
        n_drain_pend = r_drain_pend;
        o_we         = 1'b0;
        o_cmd_push   = 1'b0;
        o_cmd        = '0;
        if (i_drain_done) begin
            n_drain_pend = 1'b0;
        end
        if (accept) begin
            unique case (r_phase)
                PH_ADDR: begin
                    if (i_rx_byte == i_own_address) begin
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_check = '0;
                    end
                end
                PH_LEN: begin
                    n_check = i_rx_byte;
                    n_phase = PH_MARK;
                end
                PH_MARK: begin
                    if (i_rx_byte != MARKER_BYTE) begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_check = '0;
                    end else if (size_bad) begin
                        o_cmd_push = 1'b1;
                        o_cmd.kind = KIND_SIZE;
                        n_phase    = PH_HUNT;
                        n_count    = '0;
                        n_check    = '0;
                    end else begin
                        n_count = '0;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_we    = (r_count < MAX_P);
                    n_count = count_inc;
                    n_check = r_check ^ i_rx_byte;
                    if (count_inc >= i_frame_size || count_inc >= MAX_P) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_cmd_push = 1'b1;
                    if (r_check == i_rx_byte) begin
                        o_cmd.kind   = KIND_GOOD;
                        o_cmd.count  = r_count;
                        n_drain_pend = 1'b1;
                    end else begin
                        o_cmd.kind = KIND_CSUM;
                    end
                    n_phase = PH_HUNT;
                    n_count = '0;
                    n_check = '0;
                end
                default: begin
                    n_phase = (i_rx_byte == START_BYTE) ? PH_ADDR : PH_HUNT;
                    n_count = '0;
                    n_check = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_count      <= '0;
            r_check      <= '0;
            r_drain_pend <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_check      <= n_check;
            r_drain_pend <= n_drain_pend;
        end
    end

    // Never overwrite the store while a good frame waits to be read out
    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> !r_drain_pend)
        else $error("payload store written during drain");

    // A good frame command always carries at least one byte and finds room in the command queue
    a_good_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && o_cmd.kind == KIND_GOOD) |-> (o_cmd.count != '0 && !i_cmd_full))
        else $error("bad good-frame command");

endmodule

### rtl/afr_back.sv
// Back end: turns commands into result items, reading out stored payload.
`timescale 1ns / 1ps

module afr_back #(
    parameter int MAX_PAYLOAD = 64,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  afr_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_pop,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr,
    input  logic [7:0]                  i_rdata,
    output logic                        o_res_push,
    output afr_pkg::t_result            o_res,
    input  logic [afr_pkg::OUT_CW-1:0]  i_out_count,
    output logic                        o_drain_done
);
    import afr_pkg::*;

    logic       r_busy, n_busy;
    logic       r_rd_vld;
    logic       r_rd_last;
    logic [6:0] r_idx, n_idx;
    logic [6:0] r_cnt, n_cnt;
    logic       space;
    logic       issue;
    logic       start;
    logic       last_rd;

    // Reserve a queue slot for every read in flight
    assign space   = ((OUT_CW+1)'(i_out_count) + (OUT_CW+1)'(r_rd_vld)) <
                     (OUT_CW+1)'(OUT_DEPTH);
    assign issue   = r_busy && space;
    assign start   = !r_busy && !r_rd_vld && !i_cmd_empty && space;
    assign last_rd = (r_idx + 7'd1) == r_cnt;

    assign o_cmd_pop    = start;
    assign o_re         = issue;
    assign o_raddr      = r_idx[AW-1:0];
    assign o_drain_done = issue && last_rd;

    // Push read data, or a one-shot status result
    always_comb begin
        o_res_push = 1'b0;
        o_res      = '0;
        if (r_rd_vld) begin
            o_res_push     = 1'b1;
            o_res.kind     = KIND_GOOD;
            o_res.data     = i_rdata;
            o_res.last     = r_rd_last;
            o_res.send_ack = r_rd_last;
        end else if (start && i_cmd.kind != KIND_GOOD) begin
            o_res_push = 1'b1;
            o_res.kind = i_cmd.kind;
            o_res.last = 1'b1;
        end
    end

    // Walk the stored payload
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_cnt  = r_cnt;
        if (start && i_cmd.kind == KIND_GOOD) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_cnt  = i_cmd.count;
        end else if (issue) begin
            n_idx = r_idx + 7'd1;
            if (last_rd) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        if (issue) begin
            r_rd_last <= last_rd;
        end
    end

    // A result push must always find room in the queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (i_out_count < OUT_CW'(OUT_DEPTH)))
        else $error("result pushed into full queue");

    // Each read issued yields exactly one result next cycle
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> (o_res_push && o_res.kind == KIND_GOOD))
        else $error("payload read did not produce a result");

endmodule

### rtl/addressed_frame_receiver_top.sv
// Top level: configuration registers, front/back halves, payload store, queues.
// Status results pass the command queue and result queue; good-frame payload
// also passes the registered store read. Throughput: one byte per cycle, but
// marker/checksum bytes stall on a full command queue, next-frame payload
// bytes while a good frame drains (one byte per cycle, given result room).
// Reset (synchronous, active low): hunting, queues empty, own_address 0,
// frame_size 1; the payload store is not cleared.
`timescale 1ns / 1ps

module addressed_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input
    input  logic        push,
    input  logic [7:0]  i_rx_byte,
    output logic        full,
    // Results
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data,
    output logic        o_last,
    output logic        o_send_ack,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import afr_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CQ_CW = $clog2(CMD_DEPTH) + 1;

    logic [7:0]  r_own_address;
    logic [6:0]  r_frame_size;
    logic        cfg_wr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic        cmd_push;
    t_cmd        cmd_in;
    t_cmd        cmd_out;
    logic        cmd_full;
    logic        cmd_empty;
    logic        cmd_pop;
    logic [CQ_CW-1:0] cmd_count;
    logic        drain_done;

    logic        res_push;
    t_result     res_in;
    t_result     res_out;
    logic        res_full;
    logic [OUT_CW-1:0] res_count;

    // Configuration writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= 8'd0;
            r_frame_size  <= 7'd1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_OWN_ADDR:   r_own_address <= pwdata[7:0];
                REG_FRAME_SIZE: r_frame_size  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            REG_FRAME_SIZE: prdata = {25'd0, r_frame_size};
            default:        prdata = {24'd0, r_own_address};
        endcase
    end

    afr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_rx_byte     (i_rx_byte),
        .o_full        (full),
        .i_own_address (r_own_address),
        .i_frame_size  (r_frame_size),
        .o_we          (ram_we),
        .o_waddr       (ram_waddr),
        .o_wdata       (ram_wdata),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .i_cmd_full    (cmd_full),
        .i_drain_done  (drain_done)
    );

    afr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    afr_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    afr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_out),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .o_re         (ram_re),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_out_count  (res_count),
        .o_drain_done (drain_done)
    );

    afr_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_kind     = res_out.kind;
    assign o_data     = res_out.data;
    assign o_last     = res_out.last;
    assign o_send_ack = res_out.send_ack;

    // Command queue count never exceeds its depth
    a_cmd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_count <= CQ_CW'(CMD_DEPTH))
        else $error("command queue overrun");

    // Back end never pushes into a full result queue
    a_res_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result queue overrun");

endmodule
